// File: rtl/core/td_pkg.sv
package td_pkg;

    localparam int unsigned MaxNodesDef = 1024;
    localparam int unsigned FieldW      = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_B,
        ST_CLR,
        ST_STK_RD,
        ST_ADJ_RD,
        ST_ADJ_USE,
        ST_PUSH,
        ST_SCAN,
        ST_SCAN_USE,
        ST_DONE,
        ST_HEAD_CLR
    } t_state;

    // Sequencer status toward the datapath.
    typedef struct packed {
        logic second_pass;
        logic emit;
    } t_ctl;

endpackage

// File: rtl/core/td_scan_unit.sv
// Running best (lowest index at greatest depth) over a node sweep.
module td_scan_unit #(
    parameter int unsigned NW = 11,
    parameter int unsigned DW = 11
) (
    input  logic          i_clk,
    input  logic          i_init,
    input  logic          i_step,
    input  logic [NW-1:0] i_node,
    input  logic [DW-1:0] i_depth,
    output logic [NW-1:0] o_best,
    output logic [DW-1:0] o_best_depth
);
    logic [NW-1:0] r_best;
    logic [DW-1:0] r_bdep;

    // Seed with node one at depth of node one; replace only on strictly greater.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_best <= NW'(1);
            r_bdep <= i_depth;
        end else if (i_step && (i_depth > r_bdep)) begin
            r_best <= i_node;
            r_bdep <= i_depth;
        end
    end

    assign o_best       = r_best;
    assign o_best_depth = r_bdep;
endmodule

// File: rtl/core/tree_diameter_core.sv
// An accepted edge word holds busy through ST_INS_B; a dropped edge word never raises busy.
// A compute word holds busy for two passes and the head-store clear; each pass clears MAX_NODES
// depth and seen entries, walks the stack, then sweeps the effective node count. o_valid pulses
// in the cycle after the second pass, then busy stays high while the head store clears; the
// receiver cannot stall.
// Reset (synchronous, active low) empties the edge store with a sweep of the head store.
module tree_diameter_core #(
    parameter int unsigned MAX_NODES = td_pkg::MaxNodesDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [td_pkg::FieldW-1:0] i_node_a,
    input  logic [td_pkg::FieldW-1:0] i_node_b,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [td_pkg::FieldW-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [td_pkg::FieldW-1:0] o_first_end,
    output logic [td_pkg::FieldW-1:0] o_second_end,
    output logic [td_pkg::FieldW-1:0] o_path_nodes
);
    import td_pkg::*;

    localparam int unsigned Slots = 2 * (MAX_NODES - 1);
    localparam int unsigned NW    = $clog2(MAX_NODES + 1);
    localparam int unsigned AW    = $clog2(MAX_NODES);
    localparam int unsigned EW    = $clog2(Slots + 1);
    localparam int unsigned SW    = $clog2(Slots);
    localparam int unsigned DW    = NW;

    // Memories
    logic [EW-1:0] m_head [MAX_NODES];
    logic [EW-1:0] m_next [Slots];
    logic [NW-1:0] m_tgt  [Slots];
    logic [DW-1:0] m_dep  [MAX_NODES];
    logic          m_seen [MAX_NODES];
    logic [NW-1:0] m_snode[MAX_NODES];
    logic [EW-1:0] m_sedge[MAX_NODES];

    t_state        r_state, n_state;
    logic [FieldW-1:0] r_cfg;
    logic [NW-1:0] eff_n;
    logic [NW-1:0] r_cnt;
    logic [NW-1:0] r_etot;
    logic [NW-1:0] r_a, r_b;
    logic [NW:0]   r_sp;
    logic          r_pass;
    logic [NW-1:0] r_top_node;
    logic [EW-1:0] r_top_edge;
    logic [EW-1:0] r_nxt;
    logic [NW-1:0] r_tgt;
    logic [DW-1:0] r_top_dep;
    logic [DW-1:0] r_rd_dep;
    logic          r_rd_seen;
    logic [EW-1:0] r_rd_head;
    logic [NW-1:0] r_far;
    logic          r_valid;
    logic [FieldW-1:0] r_o1, r_o2, r_o3;

    logic [NW-1:0] best;
    logic [DW-1:0] best_dep;
    logic [NW-1:0] start_node;
    t_ctl          ctl;

    // Effective node count, saturated to 1..MAX_NODES.
    always_comb begin
        if (r_cfg == '0)
            eff_n = NW'(1);
        else if ({21'd0, r_cfg} > 32'(MAX_NODES))
            eff_n = NW'(MAX_NODES);
        else
            eff_n = NW'(r_cfg);
    end

    assign ctl.second_pass = r_pass;
    assign ctl.emit = (r_state == ST_SCAN_USE) && (r_cnt == eff_n) && r_pass;
    assign start_node = ctl.second_pass ? r_far : NW'(1);

    // Edge acceptance check.
    logic edge_ok;
    logic [NW-1:0] ia, ib;
    assign ia = NW'(i_node_a);
    assign ib = NW'(i_node_b);
    always_comb begin
        edge_ok = (i_node_a != '0) && (i_node_b != '0) && (i_node_a != i_node_b)
               && ({21'd0, i_node_a} <= {{(32-NW){1'b0}}, eff_n})
               && ({21'd0, i_node_b} <= {{(32-NW){1'b0}}, eff_n})
               && ({{(32-NW){1'b0}}, r_etot} + 32'd1 < {{(32-NW){1'b0}}, eff_n} + 32'd0
                   || {{(32-NW){1'b0}}, r_etot} < {{(32-NW){1'b0}}, eff_n} - 32'd1)
               && ({{(32-NW){1'b0}}, r_etot} < 32'(MAX_NODES - 1));
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    logic [AW-1:0] top_idx;
    assign top_idx = AW'(r_sp - 1'b1);

    // Sweep result: fold the last node into the running best; node one alone on a
    // single-node sweep.
    logic [NW-1:0] fin_best;
    logic [DW-1:0] fin_dep;
    always_comb begin
        if (r_cnt == NW'(1)) begin
            fin_best = NW'(1);
            fin_dep  = r_rd_dep;
        end else if (r_rd_dep > best_dep) begin
            fin_best = r_cnt;
            fin_dep  = r_rd_dep;
        end else begin
            fin_best = best;
            fin_dep  = best_dep;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (!i_req_type) n_state = edge_ok ? ST_INS_B : ST_IDLE;
                    else n_state = ST_CLR;
                end
            end
            ST_INS_B:    n_state = ST_IDLE;
            ST_CLR:      n_state = (r_cnt == NW'(MAX_NODES - 1)) ? ST_STK_RD : ST_CLR;
            ST_STK_RD: begin
                if (r_sp == '0) n_state = ST_SCAN;
                else n_state = ST_ADJ_RD;
            end
            ST_ADJ_RD: begin
                if (r_top_edge == '0 || {1'b0, r_top_edge} > (EW+1)'(Slots))
                    n_state = ST_STK_RD;
                else
                    n_state = ST_ADJ_USE;
            end
            ST_ADJ_USE:  n_state = ST_PUSH;
            ST_PUSH:     n_state = ST_STK_RD;
            ST_SCAN:     n_state = ST_SCAN_USE;
            ST_SCAN_USE: begin
                if (r_cnt == eff_n) n_state = r_pass ? ST_HEAD_CLR : ST_CLR;
                else n_state = ST_SCAN_USE;
            end
            ST_HEAD_CLR: n_state = (r_cnt == NW'(MAX_NODES - 1)) ? ST_IDLE : ST_HEAD_CLR;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_HEAD_CLR;
        else          r_state <= n_state;
    end

    // Sequencer counters and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= FieldW'(1);
            r_cnt   <= '0;
            r_etot  <= '0;
            r_sp    <= '0;
            r_pass  <= 1'b0;
            r_far   <= NW'(1);
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl.emit;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;
            case (r_state)
                ST_IDLE: begin
                    r_cnt  <= '0;
                    r_pass <= 1'b0;
                    if (start && !i_req_type && edge_ok) begin
                        r_a <= ia;
                        r_b <= ib;
                    end
                end
                ST_INS_B: r_etot <= r_etot + 1'b1;
                ST_CLR: begin
                    if (r_cnt == NW'(MAX_NODES - 1)) begin
                        r_sp  <= (NW+1)'(1);
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_ADJ_RD: begin
                    if (r_top_edge == '0 || {1'b0, r_top_edge} > (EW+1)'(Slots))
                        r_sp <= r_sp - 1'b1;
                end
                ST_PUSH: begin
                    if (r_tgt != '0 && {1'b0, r_tgt} <= (NW+1)'(MAX_NODES) && !r_rd_seen
                        && r_sp < (NW+1)'(MAX_NODES))
                        r_sp <= r_sp + 1'b1;
                end
                ST_SCAN: r_cnt <= NW'(1);
                ST_SCAN_USE: begin
                    if (r_cnt == eff_n) begin
                        r_cnt <= '0;
                        if (!r_pass) begin
                            r_far  <= fin_best;
                            r_pass <= 1'b1;
                        end else begin
                            r_etot <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_HEAD_CLR: begin
                    if (r_cnt == NW'(MAX_NODES - 1)) r_cnt <= '0;
                    else r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Final result registers.
    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_o1 <= FieldW'(r_far);
            r_o2 <= FieldW'(fin_best);
            r_o3 <= FieldW'(fin_dep + 1'b1);
        end
    end

    // Stack and adjacency memories, one access per port a cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start && !i_req_type && edge_ok) begin
                    m_tgt[SW'({r_etot, 1'b0})]  <= ib;
                    m_next[SW'({r_etot, 1'b0})] <= m_head[AW'(ia - 1'b1)];
                    m_head[AW'(ia - 1'b1)]      <= EW'({r_etot, 1'b0}) + 1'b1;
                end
            end
            ST_INS_B: begin
                m_tgt[SW'({r_etot, 1'b1})]  <= r_a;
                m_next[SW'({r_etot, 1'b1})] <= m_head[AW'(r_b - 1'b1)];
                m_head[AW'(r_b - 1'b1)]     <= EW'({r_etot, 1'b1}) + 1'b1;
            end
            ST_CLR: begin
                // Clear depth and seen; mark the start node as the sweep passes it.
                m_dep[AW'(r_cnt)]  <= '0;
                m_seen[AW'(r_cnt)] <= (r_cnt == start_node - 1'b1);
                if (r_cnt == NW'(MAX_NODES - 1)) begin
                    m_snode[0] <= start_node;
                    m_sedge[0] <= m_head[AW'(start_node - 1'b1)];
                end
            end
            ST_STK_RD: begin
                r_top_node <= m_snode[top_idx];
                r_top_edge <= m_sedge[top_idx];
            end
            ST_ADJ_RD: begin
                r_nxt     <= m_next[SW'(r_top_edge - 1'b1)];
                r_tgt     <= m_tgt[SW'(r_top_edge - 1'b1)];
                r_top_dep <= m_dep[AW'(r_top_node - 1'b1)];
            end
            ST_ADJ_USE: begin
                m_sedge[top_idx] <= r_nxt;
                r_rd_seen <= m_seen[AW'(r_tgt - 1'b1)];
                r_rd_head <= m_head[AW'(r_tgt - 1'b1)];
            end
            ST_PUSH: begin
                if (r_tgt != '0 && {1'b0, r_tgt} <= (NW+1)'(MAX_NODES) && !r_rd_seen
                    && r_sp < (NW+1)'(MAX_NODES)) begin
                    m_seen[AW'(r_tgt - 1'b1)] <= 1'b1;
                    m_dep[AW'(r_tgt - 1'b1)]  <= r_top_dep + 1'b1;
                    m_snode[AW'(r_sp)] <= r_tgt;
                    m_sedge[AW'(r_sp)] <= r_rd_head;
                end
            end
            ST_SCAN: r_rd_dep <= m_dep[0];
            ST_SCAN_USE: r_rd_dep <= m_dep[AW'(r_cnt)];
            ST_HEAD_CLR: m_head[AW'(r_cnt)] <= '0;
            default: ;
        endcase
    end

    // Sweep stepping: r_rd_dep holds depth of node r_cnt during ST_SCAN_USE.
    td_scan_unit #(.NW(NW), .DW(DW)) u_scan (
        .i_clk       (i_clk),
        .i_init      (r_state == ST_SCAN_USE && r_cnt == NW'(1)),
        .i_step      (r_state == ST_SCAN_USE && r_cnt != NW'(1) && r_cnt != eff_n),
        .i_node      (r_cnt),
        .i_depth     (r_rd_dep),
        .o_best      (best),
        .o_best_depth(best_dep)
    );

    assign o_valid      = r_valid;
    assign o_first_end  = r_o1;
    assign o_second_end = r_o2;
    assign o_path_nodes = r_o3;
endmodule

// File: rtl/core/td_checker.sv
module td_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic                      o_cfg_ready,
    input logic [td_pkg::FieldW-1:0] o_first_end,
    input logic [td_pkg::FieldW-1:0] o_second_end,
    input logic [td_pkg::FieldW-1:0] o_path_nodes
);
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("config ready while busy");
    a_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_end != '0 && o_second_end != '0 && o_path_nodes != '0))
        else $error("zero node in result");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
endmodule

bind tree_diameter_core td_checker u_td_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_cfg_ready(o_cfg_ready), .o_first_end(o_first_end),
    .o_second_end(o_second_end), .o_path_nodes(o_path_nodes)
);

// File: test/tb_tree_diameter_core.sv
module tb_tree_diameter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import td_pkg::*;

    localparam int unsigned MaxN     = MaxNodesDef;
    localparam int unsigned SlotN    = 2 * (MaxN - 1);
    localparam logic        REQ_EDGE = 1'b0;
    localparam logic        REQ_DIAM = 1'b1;

    typedef logic [FieldW-1:0] t_node;

    typedef struct {
        t_node first_end;
        t_node second_end;
        t_node path_nodes;
    } t_diam;

    // Diameter predictor plus the queue of diameters still owed by the block.
    class diam_scoreboard;
        int unsigned node_count;
        int unsigned edge_total;
        int unsigned head[0:MaxN];
        int unsigned nxt[0:SlotN-1];
        int unsigned tgt[0:SlotN-1];
        int unsigned depth[0:MaxN];
        bit          seen[0:MaxN];
        int unsigned stk_node[0:MaxN-1];
        int unsigned stk_edge[0:MaxN-1];
        t_diam       pending[$];
        int unsigned errors;

        function new();
            node_count = 1;
            edge_total = 0;
            errors     = 0;
            for (int i = 0; i <= MaxN; i++) begin
                head[i] = 0;
            end
        endfunction

        function void set_count(int unsigned v);
            node_count = v & 11'h7ff;
        endfunction

        function int unsigned eff_count();
            if (node_count < 1) return 1;
            if (node_count > MaxN) return MaxN;
            return node_count;
        endfunction

        function void link_half(int unsigned slot, int unsigned from, int unsigned to);
            tgt[slot]  = to;
            nxt[slot]  = head[from];
            head[from] = slot + 1;
        endfunction

        // Depth-first walk with an explicit stack; newest edge of a node first.
        function void walk_from(int unsigned s);
            int unsigned sp;
            int unsigned top;
            int unsigned e;
            int unsigned t;
            for (int i = 0; i <= MaxN; i++) begin
                depth[i] = 0;
                seen[i]  = 0;
            end
            seen[s]     = 1;
            stk_node[0] = s;
            stk_edge[0] = head[s];
            sp = 1;
            while (sp > 0) begin
                top = sp - 1;
                e   = stk_edge[top];
                if (e == 0 || e > SlotN) begin
                    sp--;
                    continue;
                end
                stk_edge[top] = nxt[e-1];
                t = tgt[e-1];
                if (t >= 1 && t <= MaxN && !seen[t] && sp < MaxN) begin
                    seen[t]      = 1;
                    depth[t]     = depth[stk_node[top]] + 1;
                    stk_node[sp] = t;
                    stk_edge[sp] = head[t];
                    sp++;
                end
            end
        endfunction

        // Lowest-numbered node at the greatest depth among 1..n.
        function int unsigned farthest_node(int unsigned n);
            int unsigned best;
            best = 1;
            for (int unsigned i = 1; i <= n; i++) begin
                if (depth[i] > depth[best]) best = i;
            end
            return best;
        endfunction

        // Note one accepted word: store an edge or predict a diameter.
        function void note_word(logic req, t_node a, t_node b);
            int unsigned n;
            int unsigned far1;
            int unsigned far2;
            t_diam       d;
            n = eff_count();
            if (req == REQ_EDGE) begin
                if (a < 1 || a > n || b < 1 || b > n || a == b) return;
                if (edge_total >= n - 1) return;
                if (edge_total >= MaxN - 1) return;
                link_half(edge_total * 2, a, b);
                link_half(edge_total * 2 + 1, b, a);
                edge_total++;
                return;
            end
            walk_from(1);
            far1 = farthest_node(n);
            walk_from(far1);
            far2 = farthest_node(n);
            d.first_end  = t_node'(far1);
            d.second_end = t_node'(far2);
            d.path_nodes = t_node'(depth[far2] + 1);
            pending = {pending, d};
            edge_total = 0;
            for (int i = 0; i <= MaxN; i++) begin
                head[i] = 0;
            end
        endfunction

        function void check_result(t_node f, t_node s, t_node p);
            t_diam d;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result first=%0d second=%0d path=%0d",
                         $time, f, s, p);
                errors++;
                return;
            end
            d = pending.pop_front();
            if (f !== d.first_end) begin
                $display("%0t: first_end expected %0d actual %0d", $time, d.first_end, f);
                errors++;
            end
            if (s !== d.second_end) begin
                $display("%0t: second_end expected %0d actual %0d",
                         $time, d.second_end, s);
                errors++;
            end
            if (p !== d.path_nodes) begin
                $display("%0t: path_nodes expected %0d actual %0d",
                         $time, d.path_nodes, p);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  i_req_type = 1'b0;
    t_node i_node_a = '0;
    t_node i_node_b = '0;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    t_node i_cfg_data = '0;
    logic  o_valid;
    t_node o_first_end;
    t_node o_second_end;
    t_node o_path_nodes;

    diam_scoreboard sb = new();
    int unsigned    burst_left = 0;
    int unsigned    word_count = 0;

    tree_diameter_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_first_end  (o_first_end),
        .o_second_end (o_second_end),
        .o_path_nodes (o_path_nodes)
    );

    always #1 i_clk = ~i_clk;

    // Check each strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_first_end, o_second_end, o_path_nodes);
    end

    // Hold one word until the block takes it, then idle between bursts.
    task automatic send_word(logic req, t_node a, t_node b);
        int unsigned gap;
        start      <= 1'b1;
        i_req_type <= req;
        i_node_a   <= a;
        i_node_b   <= b;
        do @(posedge i_clk); while (busy);
        sb.note_word(req, a, b);
        word_count++;
        if (burst_left == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_edge(int unsigned a, int unsigned b);
        send_word(REQ_EDGE, t_node'(a), t_node'(b));
    endtask

    task automatic send_diam();
        send_word(REQ_DIAM, t_node'($urandom_range(0, 2047)), t_node'($urandom_range(0, 2047)));
    endtask

    // Drain results, let the head clear finish, then write node_count.
    task automatic write_count(int unsigned v);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (MaxN + 16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t_node'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Random tree over k labels rooted at node 1, with some noise words.
    task automatic load_tree(int unsigned n, int unsigned k);
        int unsigned lab[];
        int unsigned j;
        lab = new[k];
        lab[0] = 1;
        for (int unsigned i = 1; i < k; i++) begin
            lab[i] = $urandom_range(1, n);
        end
        for (int unsigned i = 1; i < k; i++) begin
            if ($urandom_range(0, 9) == 0) send_edge($urandom_range(0, 2047),
                                                     $urandom_range(0, 2047));
            j = $urandom_range(0, i - 1);
            if ($urandom_range(0, 1)) send_edge(lab[i], lab[j]);
            else send_edge(lab[j], lab[i]);
        end
        // Extra edges past a full tree are dropped.
        if ($urandom_range(0, 3) == 0) send_edge($urandom_range(1, n), $urandom_range(1, n));
    endtask

    initial begin
        int unsigned n;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store at reset count.
        send_diam();
        // Out-of-range, self-loop and repeated edges.
        write_count(6);
        send_edge(0, 3);
        send_edge(2047, 1);
        send_edge(7, 2);
        send_edge(3, 3);
        send_edge(1, 2);
        send_edge(2, 3);
        send_edge(1, 2);
        send_edge(6, 5);
        send_diam();
        // Too many edges for the count.
        write_count(3);
        send_edge(1, 2);
        send_edge(2, 3);
        send_edge(1, 3);
        send_diam();
        // Count shrunk after loading.
        write_count(8);
        for (int unsigned i = 1; i < 8; i++) send_edge(i, i + 1);
        write_count(4);
        send_diam();
        // Saturated counts.
        write_count(0);
        send_edge(1, 1);
        send_diam();
        write_count(2047);
        send_edge(1024, 1);
        send_edge(1, 1023);
        send_edge(1025, 1);
        send_diam();
        load_tree(MaxN, 120);
        send_diam();

        // Random phases, mostly small trees.
        n = 2;
        write_count(n);
        while (word_count < 1500) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 15))
                    0:       n = 0;
                    1:       n = 2047;
                    2:       n = 1;
                    3:       n = MaxN;
                    default: n = $urandom_range(2, 40);
                endcase
                write_count(n);
            end
            load_tree(sb.eff_count(), $urandom_range(1, (sb.eff_count() > 60) ? 60
                                                                              : sb.eff_count()));
            send_diam();
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * MaxN + 64) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_tree_diameter_core: clean");
        end else begin
            $display("tb_tree_diameter_core: errors");
        end
        $finish;
    end

    // Abort a hung run.
    initial begin
        #50000000;
        $display("tb_tree_diameter_core: errors");
        $finish;
    end

endmodule
